/* sv/mpct_pkg.sv */
// Package for the mouse packet cursor tracker: constants, codes and shared types.
package mpct_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int PKT_DEPTH_DEF  = 2;
	localparam int OUT_DEPTH_DEF  = 2;

	localparam int BYTE_BITS  = 8;
	localparam int SIZE_BITS  = 13;
	localparam int OUT_BITS   = 12;
	localparam int DELTA_BITS = 10;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd1024;
	localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd768;

	localparam logic [BYTE_BITS-1:0] FLAG_ALWAYS_ONE = 8'h08;
	localparam int FLAG_X_SIGN_BIT = 4;
	localparam int FLAG_Y_SIGN_BIT = 5;
	localparam int FLAG_X_OVF_BIT  = 6;
	localparam int FLAG_Y_OVF_BIT  = 7;

	localparam logic signed [DELTA_BITS-1:0] SIGN_WEIGHT = 10'sd256;
	localparam logic signed [DELTA_BITS-1:0] OVF_EXTRA   = 10'sd255;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} mpct_reg_t;

	typedef enum logic [1:0] {
		PH_FLAGS = 2'd0,
		PH_XBYTE = 2'd1,
		PH_YBYTE = 2'd2
	} mpct_phase_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] flags;
		logic [BYTE_BITS-1:0] x_byte;
		logic [BYTE_BITS-1:0] y_byte;
	} mpct_pkt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mpct_qstat_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] x;
		logic [OUT_BITS-1:0] y;
	} mpct_res_t;

endpackage

/* sv/mpct_queue.sv */
// Small first-in first-out queue built from registers.
module mpct_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 pop,
	output logic [WIDTH-1:0]     rdata,
	output mpct_pkg::mpct_qstat_t status
);
	import mpct_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push_ok;
	logic             pop_ok;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign push_ok = push && !status.full;
	assign pop_ok  = pop && !status.empty;
	assign rdata   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push_ok) - CW'(pop_ok);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue holds more beats than its depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("beat pushed into a full queue");

endmodule

/* sv/mpct_framer.sv */
// Front part: accepts mouse bytes and frames them into three-byte packets.
module mpct_framer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [mpct_pkg::BYTE_BITS-1:0] data_byte,
	input  mpct_pkg::mpct_qstat_t          pkt_status,
	output logic                           pkt_push,
	output mpct_pkg::mpct_pkt_t            pkt
);
	import mpct_pkg::*;

	mpct_phase_t          phase_q;
	mpct_phase_t          phase_next;
	logic [BYTE_BITS-1:0] flags_q;
	logic [BYTE_BITS-1:0] x_byte_q;
	logic                 accept;
	logic                 load_flags;
	logic                 load_x;
	logic                 is_flags;

	assign full     = pkt_status.full;
	assign accept   = push && !pkt_status.full;
	assign is_flags = ((data_byte & FLAG_ALWAYS_ONE) != '0);

	always_comb begin
		phase_next = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_XBYTE: phase_next = PH_YBYTE;
				PH_YBYTE: phase_next = PH_FLAGS;
				// The unused code behaves as the flags phase.
				default:  phase_next = is_flags ? PH_XBYTE : PH_FLAGS;
			endcase
		end
	end

	always_comb begin
		load_flags = 1'b0;
		load_x     = 1'b0;
		pkt_push   = 1'b0;
		unique case (phase_q)
			PH_XBYTE: load_x     = accept;
			PH_YBYTE: pkt_push   = accept;
			default:  load_flags = accept && is_flags;
		endcase
	end

	assign pkt.flags  = flags_q;
	assign pkt.x_byte = x_byte_q;
	assign pkt.y_byte = data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FLAGS;
			flags_q  <= '0;
			x_byte_q <= '0;
		end else begin
			phase_q <= phase_next;
			if (load_flags) begin
				flags_q <= data_byte;
			end
			if (load_x) begin
				x_byte_q <= data_byte;
			end
		end
	end

	a_push_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_push |=> phase_q == PH_FLAGS)
		else $error("framing did not restart after a complete packet");

	a_bad_first: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (phase_q != PH_XBYTE) && (phase_q != PH_YBYTE) && !is_flags
		|=> phase_q == PH_FLAGS && $stable(flags_q))
		else $error("first byte without its marker bit was not dropped");

endmodule

/* sv/mpct_tracker.sv */
// Back part: decodes packets, moves and clamps the cursor, holds the screen size.
module mpct_tracker #(
	parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mpct_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mpct_pkg::SIZE_BITS-1:0]    cfg_data,
	input  mpct_pkg::mpct_qstat_t             pkt_status,
	input  mpct_pkg::mpct_pkt_t               pkt,
	output logic                              pkt_pop,
	input  mpct_pkg::mpct_qstat_t             res_status,
	output logic                              res_push,
	output mpct_pkg::mpct_res_t               res
);
	import mpct_pkg::*;

	localparam int SW   = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
	localparam int MINB = (COORD_BITS < OUT_BITS) ? COORD_BITS : OUT_BITS;
	localparam logic [COORD_BITS-1:0] CAP = '1;

	logic [SIZE_BITS-1:0]          width_q;
	logic [SIZE_BITS-1:0]          height_q;
	logic [COORD_BITS-1:0]         pos_x_q;
	logic [COORD_BITS-1:0]         pos_y_q;
	logic signed [DELTA_BITS-1:0]  dx;
	logic signed [DELTA_BITS-1:0]  dy;
	logic signed [SW-1:0]          vx;
	logic signed [SW-1:0]          vy;
	logic [COORD_BITS-1:0]         new_x;
	logic [COORD_BITS-1:0]         new_y;

	function automatic logic signed [DELTA_BITS-1:0] delta_of(
		input logic [BYTE_BITS-1:0] b,
		input logic                 neg,
		input logic                 ovf
	);
		logic signed [DELTA_BITS-1:0] d;
		d = $signed(DELTA_BITS'(b));
		// A set sign bit makes the byte the low part of a nine-bit negative value.
		if (neg) begin
			d = d - SIGN_WEIGHT;
		end
		if (ovf) begin
			d = neg ? d - OVF_EXTRA : d + OVF_EXTRA;
		end
		return d;
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp_coord(
		input logic signed [SW-1:0]  v,
		input logic [SIZE_BITS-1:0]  size
	);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] r;
		hi = $signed(SW'(size)) - SW'(1);
		if (hi > $signed(SW'(CAP))) begin
			hi = $signed(SW'(CAP));
		end
		r = v;
		if (v < 0) begin
			r = '0;
		end else if (v > hi) begin
			r = hi;
		end
		if (size == '0) begin
			r = '0;
		end
		return COORD_BITS'(r);
	endfunction

	assign pkt_pop  = !pkt_status.empty && !res_status.full;
	assign res_push = pkt_pop;

	always_comb begin
		dx = delta_of(pkt.x_byte, pkt.flags[FLAG_X_SIGN_BIT], pkt.flags[FLAG_X_OVF_BIT]);
		dy = delta_of(pkt.y_byte, pkt.flags[FLAG_Y_SIGN_BIT], pkt.flags[FLAG_Y_OVF_BIT]);
		vx = $signed(SW'(pos_x_q)) + SW'(dx);
		// Upward motion on the mouse means a smaller row on the screen.
		vy = $signed(SW'(pos_y_q)) - SW'(dy);
		new_x = clamp_coord(vx, width_q);
		new_y = clamp_coord(vy, height_q);
	end

	always_comb begin
		res = '0;
		res.x[MINB-1:0] = new_x[MINB-1:0];
		res.y[MINB-1:0] = new_y[MINB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (mpct_reg_t'(cfg_index))
					REG_SCREEN_WIDTH:  width_q  <= cfg_data;
					REG_SCREEN_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (pkt_pop) begin
				pos_x_q <= new_x;
				pos_y_q <= new_y;
			end
		end
	end

	a_zero_width: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_pop && (width_q == '0) |=> pos_x_q == '0)
		else $error("cursor column moved on a screen of zero width");

	a_zero_height: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_pop && (height_q == '0) |=> pos_y_q == '0)
		else $error("cursor row moved on a screen of zero height");

endmodule

/* sv/mouse_packet_cursor_tracker.sv */
// Top level of the mouse packet cursor tracker: framer, packet queue, tracker, result queue.
// Throughput: one byte per cycle while full is low; a packet needs three accepted bytes
// and yields one result, registered in the packet queue and then in the result queue,
// where it waits to be popped; a full result queue holds packets back in the packet queue.
// Reset: asynchronous, clears framing, cursor position and both queues; the screen size
// returns to 1024 by 768.
module mouse_packet_cursor_tracker #(
	parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF,
	parameter int PKT_DEPTH  = mpct_pkg::PKT_DEPTH_DEF,
	parameter int OUT_DEPTH  = mpct_pkg::OUT_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [mpct_pkg::BYTE_BITS-1:0]    data_byte,
	output logic                              empty,
	input  logic                              pop,
	output logic [mpct_pkg::OUT_BITS-1:0]     cursor_x,
	output logic [mpct_pkg::OUT_BITS-1:0]     cursor_y,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mpct_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mpct_pkg::SIZE_BITS-1:0]    cfg_data
);
	import mpct_pkg::*;

	mpct_qstat_t pkt_status;
	mpct_qstat_t res_status;
	mpct_pkt_t   pkt_in;
	mpct_pkt_t   pkt_out;
	logic        pkt_push;
	logic        pkt_pop;
	mpct_res_t   res_in;
	mpct_res_t   res_out;
	logic        res_push;

	assign cfg_ready = 1'b1;

	mpct_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.pkt_status (pkt_status),
		.pkt_push   (pkt_push),
		.pkt        (pkt_in)
	);

	mpct_queue #(
		.WIDTH ($bits(mpct_pkt_t)),
		.DEPTH (PKT_DEPTH)
	) u_pkt_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (pkt_push),
		.wdata  (pkt_in),
		.pop    (pkt_pop),
		.rdata  (pkt_out),
		.status (pkt_status)
	);

	mpct_tracker #(
		.COORD_BITS (COORD_BITS)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pkt_status (pkt_status),
		.pkt        (pkt_out),
		.pkt_pop    (pkt_pop),
		.res_status (res_status),
		.res_push   (res_push),
		.res        (res_in)
	);

	mpct_queue #(
		.WIDTH ($bits(mpct_res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_out),
		.status (res_status)
	);

	assign empty    = res_status.empty;
	assign cursor_x = res_out.x;
	assign cursor_y = res_out.y;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the mouse packet cursor tracker, with its own cursor predictor.
module testbench;
	import mpct_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_BYTES  = 850;
	localparam int SCREEN_STEPS  = 8;
	localparam int COORD_CAP     = (1 << COORD_BITS_DEF) - 1;
	localparam int DIRECTED_ROWS = 23;
	localparam int CALM_STEP     = 6;

	// Fixed screen sizes for the random steps; the last step draws its own.
	localparam int STEP_W [SCREEN_STEPS-1] = '{0, 1, 4096, 8191, 8191, 1, 640};
	localparam int STEP_H [SCREEN_STEPS-1] = '{0, 1, 4096, 8191, 1, 8191, 480};

	typedef struct packed {
		logic [BYTE_BITS-1:0] data;
		logic                 typed;
		logic [OUT_BITS-1:0]  x;
		logic [OUT_BITS-1:0]  y;
	} directed_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic [BYTE_BITS-1:0] data_byte = '0;
	logic                 pop = 1'b0;
	logic                 cfg_valid = 1'b0;
	mpct_reg_t            cfg_index = REG_SCREEN_WIDTH;
	logic [SIZE_BITS-1:0] cfg_data = '0;
	logic                 full;
	logic                 empty;
	logic                 cfg_ready;
	logic [OUT_BITS-1:0]  cursor_x;
	logic [OUT_BITS-1:0]  cursor_y;

	// Predicted framing, cursor and screen size.
	mpct_phase_t          frame_phase = PH_FLAGS;
	logic [BYTE_BITS-1:0] held_flags = '0;
	logic [BYTE_BITS-1:0] held_x = '0;
	int                   track_x = 0;
	int                   track_y = 0;
	int                   screen_w = int'(WIDTH_RESET);
	int                   screen_h = int'(HEIGHT_RESET);

	mpct_res_t pending_cursor_q[$];
	int        mismatch_count = 0;
	int        effective_bytes = 0;
	int        cycle_count = 0;
	bit        stalls_on = 1'b1;

	// Bad first bytes, a zero byte with its sign set on either axis, both overflows,
	// every flag at once and clamping at the low edge of the default screen.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{8'h00, 1'b0, 12'd0,   12'd0},
		'{8'hF7, 1'b0, 12'd0,   12'd0},
		'{8'h08, 1'b0, 12'd0,   12'd0},
		'{8'h10, 1'b0, 12'd0,   12'd0},
		'{8'h00, 1'b1, 12'd16,  12'd0},
		'{8'h28, 1'b0, 12'd0,   12'd0},
		'{8'h00, 1'b0, 12'd0,   12'd0},
		'{8'h00, 1'b1, 12'd16,  12'd256},
		'{8'h18, 1'b0, 12'd0,   12'd0},
		'{8'h00, 1'b0, 12'd0,   12'd0},
		'{8'h00, 1'b1, 12'd0,   12'd256},
		'{8'h48, 1'b0, 12'd0,   12'd0},
		'{8'hFF, 1'b0, 12'd0,   12'd0},
		'{8'h00, 1'b1, 12'd510, 12'd256},
		'{8'hF8, 1'b0, 12'd0,   12'd0},
		'{8'h80, 1'b0, 12'd0,   12'd0},
		'{8'hFF, 1'b1, 12'd127, 12'd512},
		'{8'h88, 1'b0, 12'd0,   12'd0},
		'{8'h00, 1'b0, 12'd0,   12'd0},
		'{8'hFF, 1'b1, 12'd127, 12'd2},
		'{8'h38, 1'b0, 12'd0,   12'd0},
		'{8'h7F, 1'b0, 12'd0,   12'd0},
		'{8'h80, 1'b0, 12'd0,   12'd0}
	};

	mouse_packet_cursor_tracker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.empty     (empty),
		.pop       (pop),
		.cursor_x  (cursor_x),
		.cursor_y  (cursor_y),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int motion_delta(input logic [BYTE_BITS-1:0] b, input logic neg,
			input logic ovf);
		int d;
		d = int'(b);
		if (neg)
			d -= int'(SIGN_WEIGHT);
		if (ovf)
			d += neg ? -int'(OVF_EXTRA) : int'(OVF_EXTRA);
		return d;
	endfunction

	function automatic int clamp_to_screen(input int v, input int size);
		int hi;
		if (size == 0)
			return 0;
		hi = (size - 1 > COORD_CAP) ? COORD_CAP : size - 1;
		if (v < 0)
			return 0;
		return (v > hi) ? hi : v;
	endfunction

	// Steps the predicted framer by one byte; returns 1 when a packet completes.
	function automatic bit advance_cursor(input logic [BYTE_BITS-1:0] b, output mpct_res_t cur);
		cur = '0;
		if (frame_phase != PH_FLAGS || (b & FLAG_ALWAYS_ONE) != '0)
			effective_bytes++;
		case (frame_phase)
			PH_XBYTE: begin
				held_x = b;
				frame_phase = PH_YBYTE;
			end
			PH_YBYTE: begin
				frame_phase = PH_FLAGS;
				track_x = clamp_to_screen(track_x + motion_delta(held_x,
					held_flags[FLAG_X_SIGN_BIT], held_flags[FLAG_X_OVF_BIT]), screen_w);
				// Rows grow downwards, so upward motion lowers the row.
				track_y = clamp_to_screen(track_y - motion_delta(b,
					held_flags[FLAG_Y_SIGN_BIT], held_flags[FLAG_Y_OVF_BIT]), screen_h);
				cur.x = track_x[OUT_BITS-1:0];
				cur.y = track_y[OUT_BITS-1:0];
				return 1'b1;
			end
			default: begin
				if ((b & FLAG_ALWAYS_ONE) != '0) begin
					held_flags = b;
					frame_phase = PH_XBYTE;
				end else begin
					frame_phase = PH_FLAGS;
				end
			end
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_cursor(input logic [OUT_BITS-1:0] x, input logic [OUT_BITS-1:0] y);
		mpct_res_t want;
		if (pending_cursor_q.size() == 0) begin
			report_mismatch($sformatf("unexpected cursor beat x=%0d y=%0d", x, y));
			return;
		end
		want = pending_cursor_q.pop_front();
		if (x !== want.x)
			report_mismatch($sformatf("cursor_x %0d, expected %0d", x, want.x));
		if (y !== want.y)
			report_mismatch($sformatf("cursor_y %0d, expected %0d", y, want.y));
	endtask

	task automatic send_byte(input logic [BYTE_BITS-1:0] b, input bit typed,
			input mpct_res_t typed_cur);
		mpct_res_t cur;
		if (stalls_on) begin
			while ($urandom_range(99) < 7) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (advance_cursor(b, cur))
			pending_cursor_q.push_back(typed ? typed_cur : cur);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (pending_cursor_q.size() != 0)
			@(posedge clk);
		// A partly framed packet stays in the framer and reaches neither queue.
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_screen(input int w, input int h);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= w[SIZE_BITS-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		screen_w = w;
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= h[SIZE_BITS-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		screen_h = h;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			check_cursor(cursor_x, cursor_y);
		pop <= !stalls_on || ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		mpct_res_t            cur;
		logic [BYTE_BITS-1:0] flags;
		int                   target;
		int                   w;
		int                   h;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			cur.x = directed_rows[i].x;
			cur.y = directed_rows[i].y;
			send_byte(directed_rows[i].data, directed_rows[i].typed, cur);
		end

		target = effective_bytes;
		for (int step = 0; step < SCREEN_STEPS; step++) begin
			drain_results();
			if (step == SCREEN_STEPS - 1) begin
				w = $urandom_range(4096, 1);
				h = $urandom_range(4096, 1);
			end else begin
				w = STEP_W[step];
				h = STEP_H[step];
			end
			set_screen(w, h);
			stalls_on = (step != CALM_STEP);
			target += RANDOM_BYTES / SCREEN_STEPS;
			while (effective_bytes < target) begin
				if ($urandom_range(99) < 8) begin
					// Noise: a stray byte that may break or shift the framing.
					send_byte(8'($urandom_range(255)), 1'b0, '0);
				end else begin
					flags = 8'($urandom_range(255)) | FLAG_ALWAYS_ONE;
					// Keep most packets free of overflow so the cursor wanders the screen.
					if ($urandom_range(3) != 0) begin
						flags[FLAG_X_OVF_BIT] = 1'b0;
						flags[FLAG_Y_OVF_BIT] = 1'b0;
					end
					send_byte(flags, 1'b0, '0);
					send_byte(8'($urandom_range(255)), 1'b0, '0);
					send_byte(8'($urandom_range(255)), 1'b0, '0);
				end
			end
		end
		stalls_on = 1'b1;
		drain_results();

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* filelist.f */
sv/mpct_pkg.sv
sv/mpct_queue.sv
sv/mpct_framer.sv
sv/mpct_tracker.sv
sv/mouse_packet_cursor_tracker.sv
sim/testbench.sv
